FILE: design/gbn_pkg.sv
// Shared types, codes and default constants for the go-back-N sender.
package gbn_pkg;

    localparam int SEQ_BITS_DEF   = 16;
    localparam int MAX_WINDOW_DEF = 32;

    localparam logic [5:0]  WINDOW_RST  = 6'd4;
    localparam logic [15:0] TOTAL_RST   = 16'd15;
    localparam logic [15:0] TIMEOUT_RST = 16'd2000;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_WINDOW  = 2'd0,
        REG_TOTAL   = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_SEND  = 2'd2,
        S_CLOSE = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic emit;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic can_send;
        logic last;
        logic out_free;
    } t_status;

endpackage

FILE: design/gbn_ctrl.sv
// Controller state machine sequencing accept, evaluation, sending and timer update.
module gbn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gbn_pkg::t_status i_stat,
    output gbn_pkg::t_cmd  o_cmd
);
    import gbn_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_SEND;
            end
            S_SEND: begin
                if (!i_stat.can_send) begin
                    n_state = S_CLOSE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/gbn_datapath.sv
// Datapath holding the window pointers, timer, configuration and output register.
module gbn_datapath #(
    parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF,
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gbn_pkg::t_cmd    i_cmd,
    output gbn_pkg::t_status o_stat,
    input  logic [1:0]       i_req_type,
    input  logic [15:0]      i_ack_seq,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [15:0]      o_send_seq,
    output logic             o_is_resend,
    output logic             o_last_of_run,
    output logic             o_all_done
);
    import gbn_pkg::*;

    localparam int AW = (SEQ_BITS > 16) ? SEQ_BITS : 16;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam logic [AW:0]   ONE_SH   = (AW + 1)'(1) << SEQ_BITS;
    localparam logic [AW-1:0] SEQ_MASK = AW'(ONE_SH - (AW + 1)'(1));

    logic [5:0]          r_win;
    logic [15:0]         r_total;
    logic [15:0]         r_tmo;
    logic [SEQ_BITS-1:0] r_base;
    logic [SEQ_BITS-1:0] r_next;
    logic [15:0]         r_tcount;
    logic                r_trun;
    logic [1:0]          r_kind;
    logic [15:0]         r_ack;
    logic                r_resend;
    logic                r_fire;
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;
    logic [15:0]         r_out_seq;
    logic                r_out_resend;
    logic                r_out_last;
    logic                r_out_done;

    logic [CW-1:0] win_eff;
    logic [AW-1:0] tot_eff;
    logic [15:0]   tmo_eff;
    logic [AW-1:0] base_x;
    logic [AW-1:0] next_x;
    logic [AW-1:0] ack_x;
    logic [AW:0]   limit;
    logic [AW:0]   next_p1;
    logic [AW:0]   ack_p1;
    logic [15:0]   tc1;
    logic          ack_ok;
    logic          can_send;
    logic          last;

    always_comb begin
        if (r_win == 6'd0) begin
            win_eff = CW'(1);
        end else if ({1'b0, r_win} > 7'(MAX_WINDOW)) begin
            win_eff = CW'(MAX_WINDOW);
        end else begin
            win_eff = CW'(r_win);
        end
        tot_eff  = (AW'(r_total) > SEQ_MASK) ? SEQ_MASK : AW'(r_total);
        tmo_eff  = (r_tmo == 16'd0) ? 16'd1 : r_tmo;
        base_x   = AW'(r_base);
        next_x   = AW'(r_next);
        ack_x    = AW'(r_ack);
        limit    = (AW + 1)'(base_x) + (AW + 1)'(win_eff);
        next_p1  = (AW + 1)'(next_x) + (AW + 1)'(1);
        ack_p1   = (AW + 1)'(ack_x) + (AW + 1)'(1);
        tc1      = r_tcount + 16'd1;
        ack_ok   = (ack_x >= base_x) && (ack_x < next_x);
        can_send = r_fire && ((AW + 1)'(next_x) < limit) && (next_x < tot_eff)
                   && ((CW + 1)'(r_cnt) < (CW + 1)'(MAX_WINDOW));
        last     = !((next_p1 < limit) && (next_p1 < (AW + 1)'(tot_eff))
                   && ((CW + 1)'(r_cnt) + (CW + 1)'(1) < (CW + 1)'(MAX_WINDOW)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= WINDOW_RST;
            r_total  <= TOTAL_RST;
            r_tmo    <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW:  r_win   <= i_cfg_data[5:0];
                REG_TOTAL:   r_total <= i_cfg_data;
                REG_TIMEOUT: r_tmo   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next      <= '0;
            r_tcount    <= '0;
            r_trun      <= 1'b0;
            r_resend    <= 1'b0;
            r_fire      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_cnt    <= '0;
                r_resend <= 1'b0;
                r_fire   <= 1'b0;
                case (r_kind)
                    KIND_START: begin
                        r_fire <= 1'b1;
                    end
                    KIND_ACK: begin
                        if (ack_ok) begin
                            r_base   <= SEQ_BITS'(ack_p1);
                            r_trun   <= (ack_p1 < (AW + 1)'(next_x));
                            r_tcount <= '0;
                            r_fire   <= 1'b1;
                        end
                    end
                    KIND_TICK: begin
                        if (r_trun) begin
                            if (tc1 >= tmo_eff) begin
                                r_next   <= r_base;
                                r_tcount <= '0;
                                r_resend <= 1'b1;
                                r_fire   <= 1'b1;
                            end else begin
                                r_tcount <= tc1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_next      <= r_next + SEQ_BITS'(1);
                r_cnt       <= r_cnt + CW'(1);
            end
            if (i_cmd.close) begin
                if (base_x < next_x) begin
                    if (!r_trun) begin
                        r_trun   <= 1'b1;
                        r_tcount <= '0;
                    end
                end else begin
                    r_trun   <= 1'b0;
                    r_tcount <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_ack  <= i_ack_seq;
        end
        if (i_cmd.emit) begin
            r_out_seq    <= 16'(next_x);
            r_out_resend <= r_resend;
            r_out_last   <= last;
            r_out_done   <= (base_x >= tot_eff);
        end
    end

    assign o_stat.can_send = can_send;
    assign o_stat.last     = last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_send_seq      = r_out_seq;
    assign o_is_resend     = r_out_resend;
    assign o_last_of_run   = r_out_last;
    assign o_all_done      = r_out_done;

endmodule

FILE: design/go_back_n_sender_unit.sv
// Top level of the go-back-N sliding-window sender.
//
// Requests arrive on the slave stream: tuser carries the request kind (start,
// acknowledgement or time tick) and tdata the acknowledged sequence number.
// Each request causes zero or more send transfers on the master stream, one
// per data packet to transmit; tlast marks the final transfer of a request.
// The configuration channel writes window size, packet total and timeout; the
// user must write only while the block is idle, as the block does not enforce it.
// The channel is always ready. A request passes accept, evaluation, the send
// loop and close, and sends at most the window size of packets; the send loop
// emits one sequence number per cycle from the window pointers while output is free.
// A new request is taken as soon as the previous one has finished, even while
// its final transfer still waits in the output register.
// When the receiver stalls, the sender holds the current transfer and pauses
// the send loop until the output register frees up.
// After reset the window pointers and timer are cleared, the timer is stopped
// and the registers hold window 4, total 15 and timeout 2000.
module go_back_n_sender_unit #(
    parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF,
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ack_seq
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] send_seq
    output logic [1:0]  m_axis_tuser,   // [0] is_resend, [1] all_done
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import gbn_pkg::*;

    t_cmd    cmd;
    t_status stat;

    assign o_cfg_ready = 1'b1;

    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gbn_datapath #(
        .SEQ_BITS   (SEQ_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (s_axis_tuser),
        .i_ack_seq     (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_send_seq    (m_axis_tdata),
        .o_is_resend   (m_axis_tuser[0]),
        .o_last_of_run (m_axis_tlast),
        .o_all_done    (m_axis_tuser[1])
    );

endmodule
